// ----- rtl/sdoc_pkg.sv -----
// Shared types and constants for the expedited object-dictionary client.
package sdoc_pkg;

  // Operation codes of an input item
  localparam logic [2:0] OP_START_WRITE = 3'd0;
  localparam logic [2:0] OP_START_READ  = 3'd1;
  localparam logic [2:0] OP_RX_FRAME    = 3'd2;
  localparam logic [2:0] OP_TICK        = 3'd3;
  localparam logic [2:0] OP_RX_FAULT    = 3'd4;

  // Request command bytes
  localparam logic [7:0] CMD_WRITE_4 = 8'h23;
  localparam logic [7:0] CMD_WRITE_2 = 8'h2B;
  localparam logic [7:0] CMD_WRITE_1 = 8'h2F;
  localparam logic [7:0] CMD_READ    = 8'h40;

  // Response command bytes
  localparam logic [7:0] RSP_WRITE_OK = 8'h60;
  localparam logic [7:0] RSP_READ_OK  = 8'h40;
  localparam logic [7:0] RSP_READ_MSK = 8'hE0;
  localparam logic [7:0] RSP_ABORT    = 8'h80;

  // Fixed frame length of an expedited transfer
  localparam logic [3:0] FRAME_LENGTH = 4'd8;

  // Reset value of the timeout register (ms)
  localparam logic [31:0] TIMEOUT_RESET = 32'd1000;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_ERROR   = 2'd1,
    ST_ABORT   = 2'd2,
    ST_TIMEOUT = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]  operation;
    logic [7:0]  node_id;
    logic [15:0] index;
    logic [7:0]  subindex;
    logic [31:0] write_value;
    logic [2:0]  write_size;
    logic [10:0] rx_id;
    logic [3:0]  rx_length;
    logic [63:0] rx_data;
  } in_item_t;

  typedef struct packed {
    logic        tx_valid;
    logic [10:0] tx_id;
    logic [63:0] tx_data;
    logic        done_res;
    status_e     status;
    logic [31:0] read_value;
  } out_item_t;

endpackage

// ----- rtl/sdoc_engine.sv -----
// Transfer state and per-item decision logic of the expedited client.
module sdoc_engine import sdoc_pkg::*; #(
  parameter int unsigned MAX_NODE   = 127,
  parameter int unsigned TX_ID_BASE = 1536,
  parameter int unsigned RX_ID_BASE = 1408
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_take_i,
  input  in_item_t    item_i,
  input  logic        cfg_we_i,
  input  logic [31:0] cfg_data_i,
  output logic        res_valid_o,
  output out_item_t   res_o
);

  localparam logic [10:0] TxBase  = 11'(TX_ID_BASE);
  localparam logic [11:0] RxBase  = 12'(RX_ID_BASE);
  localparam logic [7:0]  NodeMax = 8'(MAX_NODE);

  logic [31:0] timeout_q;
  logic        busy_q, busy_d;
  logic        is_read_q, is_read_d;
  logic [6:0]  node_q, node_d;
  logic [15:0] index_q, index_d;
  logic [7:0]  sub_q, sub_d;
  logic [31:0] elapsed_q, elapsed_d;

  logic [31:0] elapsed_inc;
  logic        timed_out;
  logic        tick_out;
  logic        frame_match;
  logic [7:0]  b0;
  logic [7:0]  cmd;
  logic [31:0] payload;
  logic        size_ok;

  // Saturating millisecond count and timeout compares
  assign elapsed_inc = (elapsed_q == '1) ? elapsed_q : elapsed_q + 32'd1;
  assign timed_out   = elapsed_q >= timeout_q;
  assign tick_out    = elapsed_inc >= timeout_q;

  // Response frame must match the pending request
  assign b0 = item_i.rx_data[7:0];
  assign frame_match = ({1'b0, item_i.rx_id} == RxBase + {5'd0, node_q})
                    && (item_i.rx_length == FRAME_LENGTH)
                    && (item_i.rx_data[23:8] == index_q)
                    && (item_i.rx_data[31:24] == sub_q);

  // Command byte and data for a start
  always_comb begin
    cmd     = CMD_READ;
    payload = '0;
    size_ok = 1'b1;
    if (item_i.operation == OP_START_WRITE) begin
      case (item_i.write_size)
        3'd1: begin
          cmd     = CMD_WRITE_1;
          payload = {24'd0, item_i.write_value[7:0]};
        end
        3'd2: begin
          cmd     = CMD_WRITE_2;
          payload = {16'd0, item_i.write_value[15:0]};
        end
        3'd4: begin
          cmd     = CMD_WRITE_4;
          payload = item_i.write_value;
        end
        default: size_ok = 1'b0;
      endcase
    end
  end

  // Decision for one item
  always_comb begin
    busy_d      = busy_q;
    is_read_d   = is_read_q;
    node_d      = node_q;
    index_d     = index_q;
    sub_d       = sub_q;
    elapsed_d   = elapsed_q;
    res_valid_o = 1'b0;
    res_o       = '0;
    res_o.status = ST_OK;

    if (item_take_i) begin
      case (item_i.operation)
        OP_START_WRITE, OP_START_READ: begin
          res_valid_o = 1'b1;
          if (busy_q || item_i.node_id == 8'd0 || item_i.node_id > NodeMax || !size_ok) begin
            res_o.done_res = 1'b1;
            res_o.status   = ST_ERROR;
          end else begin
            res_o.tx_valid = 1'b1;
            res_o.tx_id    = TxBase + {3'd0, item_i.node_id};
            res_o.tx_data  = {payload, item_i.subindex, item_i.index, cmd};
            busy_d    = 1'b1;
            is_read_d = (item_i.operation == OP_START_READ);
            node_d    = item_i.node_id[6:0];
            index_d   = item_i.index;
            sub_d     = item_i.subindex;
            elapsed_d = '0;
          end
        end
        OP_TICK: begin
          if (busy_q) begin
            elapsed_d = elapsed_inc;
            if (tick_out) begin
              res_valid_o    = 1'b1;
              res_o.done_res = 1'b1;
              res_o.status   = ST_TIMEOUT;
              busy_d         = 1'b0;
            end
          end
        end
        OP_RX_FRAME, OP_RX_FAULT: begin
          if (busy_q) begin
            if (timed_out) begin
              res_valid_o    = 1'b1;
              res_o.done_res = 1'b1;
              res_o.status   = ST_TIMEOUT;
              busy_d         = 1'b0;
            end else if (item_i.operation == OP_RX_FAULT) begin
              res_valid_o    = 1'b1;
              res_o.done_res = 1'b1;
              res_o.status   = ST_ERROR;
              busy_d         = 1'b0;
            end else if (frame_match) begin
              res_valid_o    = 1'b1;
              res_o.done_res = 1'b1;
              busy_d         = 1'b0;
              if (b0 == RSP_ABORT) begin
                res_o.status = ST_ABORT;
              end else if (is_read_q) begin
                if ((b0 & RSP_READ_MSK) == RSP_READ_OK) begin
                  res_o.status     = ST_OK;
                  res_o.read_value = item_i.rx_data[63:32];
                end else begin
                  res_o.status = ST_ERROR;
                end
              end else if (b0 == RSP_WRITE_OK) begin
                res_o.status = ST_OK;
              end else begin
                res_o.status = ST_ERROR;
              end
            end
          end
        end
        default: ;
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TIMEOUT_RESET;
      busy_q    <= 1'b0;
      is_read_q <= 1'b0;
      node_q    <= '0;
      index_q   <= '0;
      sub_q     <= '0;
      elapsed_q <= '0;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_data_i;
      end
      busy_q    <= busy_d;
      is_read_q <= is_read_d;
      node_q    <= node_d;
      index_q   <= index_d;
      sub_q     <= sub_d;
      elapsed_q <= elapsed_d;
    end
  end

endmodule

// ----- rtl/sdo_expedited_client.sv -----
// Top level of the expedited object-dictionary client with result buffering.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-----------------------
//   in      | input     | in_valid_i/in_stall_o | in_data_i (in_item_t)
//   out     | output    | out_valid_o/out_stall_i | out_data_o (out_item_t)
//   cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_data_i (timeout ms)
//
// One item is taken per cycle unless the input stalls; its result is written
// to the output or, on a stall, the skid register as transfer state updates.
// One output register plus a one-entry skid buffer decouples the sides: input
// stalls only when the skid entry holds a result.
// Reset clears transfer state, restores a 1000 ms timeout and empties the output.
// The configuration port is always ready.
module sdo_expedited_client import sdoc_pkg::*; #(
  parameter int unsigned MAX_NODE   = 127,
  parameter int unsigned TX_ID_BASE = 1536,
  parameter int unsigned RX_ID_BASE = 1408
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  logic      take;
  logic      res_valid;
  out_item_t res;
  logic      out_valid_q;
  out_item_t out_q;
  logic      skid_valid_q;
  out_item_t skid_q;
  logic      out_free;

  assign in_stall_o  = skid_valid_q;
  assign take        = in_valid_i & ~skid_valid_q;
  assign cfg_ready_o = 1'b1;
  assign out_free    = ~out_valid_q | ~out_stall_i;

  sdoc_engine #(
    .MAX_NODE   (MAX_NODE),
    .TX_ID_BASE (TX_ID_BASE),
    .RX_ID_BASE (RX_ID_BASE)
  ) u_engine (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_take_i (take),
    .item_i      (in_data_i),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_data_i  (cfg_data_i),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // Output and skid valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q  <= skid_valid_q | res_valid;
      skid_valid_q <= 1'b0;
    end else if (res_valid) begin
      skid_valid_q <= 1'b1;
    end
  end

  // Output and skid payload
  always_ff @(posedge clk_i) begin
    if (out_free) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (res_valid) begin
        out_q <= res;
      end
    end else if (res_valid) begin
      skid_q <= res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

// ----- rtl/sdoc_checker.sv -----
// Port-level checks for the expedited client, bound to the top level.
module sdoc_checker import sdoc_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_stall_o,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input out_item_t out_data_o
);

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // A result is either a request frame or a completion, never both
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> out_data_o.tx_valid != out_data_o.done_res)
    else $error("result is neither or both frame and completion");

  // A request frame carries a known command and no status
  a_tx_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.tx_valid |->
      (out_data_o.tx_data[7:0] == CMD_WRITE_1 || out_data_o.tx_data[7:0] == CMD_WRITE_2 ||
       out_data_o.tx_data[7:0] == CMD_WRITE_4 || out_data_o.tx_data[7:0] == CMD_READ) &&
      out_data_o.status == ST_OK && out_data_o.read_value == 32'd0)
    else $error("bad request frame");

  // Input only stalls while a result is waiting on a stalled output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && $past(out_stall_i))
    else $error("input stalled without a waiting result");

endmodule

bind sdo_expedited_client sdoc_checker u_sdoc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

// ----- bench/tb.sv -----
// Self-checking testbench for the expedited object-dictionary client.
module tb;
  import sdoc_pkg::*;

  localparam int unsigned NODE_MAX       = 127;
  localparam int unsigned TX_BASE        = 1536;
  localparam int unsigned RX_BASE        = 1408;
  localparam logic [2:0]  OP_UNUSED      = 3'd7;
  localparam int unsigned ITEM_TARGET    = 1650;
  localparam int unsigned PHASES         = 8;
  localparam int unsigned SETTLE_CYCLES  = 8;
  localparam int unsigned WATCHDOG_LIMIT = 4000;

  // How a stimulus row gets its expected output
  typedef enum logic [1:0] {
    ROW_PREDICTED,
    ROW_NO_RESULT,
    ROW_FINISHED
  } row_kind_e;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PERIODIC
  } stall_mode_e;

  typedef struct {
    row_kind_e kind;
    status_e   st;
    in_item_t  item;
  } stim_row_t;

  logic        clk       = 1'b0;
  logic        rst_n     = 1'b0;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_data   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] cfg_data  = '0;

  // Mirror of the client state and its timeout register
  logic        xfer_busy    = 1'b0;
  logic        xfer_is_read = 1'b0;
  logic [6:0]  held_node    = '0;
  logic [15:0] held_index   = '0;
  logic [7:0]  held_sub     = '0;
  logic [31:0] elapsed_ms   = '0;
  logic [31:0] wait_limit   = TIMEOUT_RESET;

  out_item_t   client_outputs_due[$];
  stim_row_t   directed_rows[$];
  out_item_t   want;
  int unsigned mismatch_count = 0;
  int unsigned stuck_cycles   = 0;
  stall_mode_e stall_mode     = STALL_NONE;
  int unsigned stall_left     = 0;

  sdo_expedited_client #(
    .MAX_NODE   (NODE_MAX),
    .TX_ID_BASE (TX_BASE),
    .RX_ID_BASE (RX_BASE)
  ) u_top (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_data_i  (cfg_data)
  );

  always #2 clk = ~clk;

  // Client behavior: advance the mirrored state by one item, return 1 if it has an output
  function automatic bit sdo_client_step(input in_item_t it, output out_item_t res);
    logic [7:0]  cmd;
    logic [31:0] payload;
    logic [7:0]  rsp;
    res     = '0;
    cmd     = CMD_READ;
    payload = '0;
    rsp     = it.rx_data[7:0];
    if (it.operation == OP_START_WRITE || it.operation == OP_START_READ) begin
      res.done_res = 1'b1;
      res.status   = ST_ERROR;
      if (xfer_busy || it.node_id == 8'd0 || it.node_id > NODE_MAX) return 1'b1;
      if (it.operation == OP_START_WRITE) begin
        case (it.write_size)
          3'd1: begin
            cmd     = CMD_WRITE_1;
            payload = {24'd0, it.write_value[7:0]};
          end
          3'd2: begin
            cmd     = CMD_WRITE_2;
            payload = {16'd0, it.write_value[15:0]};
          end
          3'd4: begin
            cmd     = CMD_WRITE_4;
            payload = it.write_value;
          end
          default: return 1'b1;
        endcase
      end
      xfer_busy    = 1'b1;
      xfer_is_read = (it.operation == OP_START_READ);
      held_node    = it.node_id[6:0];
      held_index   = it.index;
      held_sub     = it.subindex;
      elapsed_ms   = '0;
      res          = '0;
      res.tx_valid = 1'b1;
      res.tx_id    = 11'(TX_BASE + it.node_id);
      res.tx_data  = {payload, it.subindex, it.index, cmd};
      return 1'b1;
    end
    if (!xfer_busy) return 1'b0;
    if (it.operation == OP_TICK) begin
      if (elapsed_ms != '1) elapsed_ms++;
      if (elapsed_ms < wait_limit) return 1'b0;
      res.status = ST_TIMEOUT;
    end else if (it.operation == OP_RX_FRAME || it.operation == OP_RX_FAULT) begin
      if (elapsed_ms >= wait_limit) res.status = ST_TIMEOUT;
      else if (it.operation == OP_RX_FAULT) res.status = ST_ERROR;
      else if (it.rx_id != 11'(RX_BASE + held_node) || it.rx_length != FRAME_LENGTH ||
               it.rx_data[23:8] != held_index || it.rx_data[31:24] != held_sub)
        return 1'b0;
      else if (rsp == RSP_ABORT) res.status = ST_ABORT;
      else if (xfer_is_read ? ((rsp & RSP_READ_MSK) == RSP_READ_OK) : (rsp == RSP_WRITE_OK)) begin
        res.status = ST_OK;
        if (xfer_is_read) res.read_value = it.rx_data[63:32];
      end else res.status = ST_ERROR;
    end else begin
      return 1'b0;
    end
    xfer_busy    = 1'b0;
    res.done_res = 1'b1;
    return 1'b1;
  endfunction

  function automatic in_item_t start_item(logic [2:0] op, logic [7:0] node, logic [15:0] idx,
                                          logic [7:0] sub, logic [31:0] val, logic [2:0] size);
    in_item_t it;
    it             = '0;
    it.operation   = op;
    it.node_id     = node;
    it.index       = idx;
    it.subindex    = sub;
    it.write_value = val;
    it.write_size  = size;
    return it;
  endfunction

  function automatic in_item_t frame_item(logic [10:0] id, logic [3:0] len, logic [63:0] data);
    in_item_t it;
    it           = '0;
    it.operation = OP_RX_FRAME;
    it.rx_id     = id;
    it.rx_length = len;
    it.rx_data   = data;
    return it;
  endfunction

  // All fields at ones except the operation
  function automatic in_item_t bare_item(logic [2:0] op);
    in_item_t it;
    it           = '1;
    it.operation = op;
    return it;
  endfunction

  function automatic void add_row(row_kind_e kind, status_e st, in_item_t it);
    stim_row_t row;
    row.kind = kind;
    row.st   = st;
    row.item = it;
    directed_rows.push_back(row);
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      mismatch_count++;
    end
  endfunction

  // One input transfer; the expectation is queued at the accepting edge
  task automatic send_item(input in_item_t it, input row_kind_e kind, input status_e st);
    out_item_t res;
    bit        got;
    @(negedge clk);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    got = sdo_client_step(it, res);
    if (kind == ROW_NO_RESULT) begin
      got = 1'b0;
    end else if (kind == ROW_FINISHED) begin
      res          = '0;
      res.done_res = 1'b1;
      res.status   = st;
      got          = 1'b1;
    end
    if (got) client_outputs_due.push_back(res);
  endtask

  task automatic hold_input(input int unsigned n);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    while (client_outputs_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Output check against the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (client_outputs_due.size() == 0) begin
        $error("output with no expectation waiting: %h", out_data);
        mismatch_count++;
      end else begin
        want = client_outputs_due.pop_front();
        check_field("tx_valid", want.tx_valid, out_data.tx_valid);
        check_field("tx_id", want.tx_id, out_data.tx_id);
        check_field("tx_data", want.tx_data, out_data.tx_data);
        check_field("done_res", want.done_res, out_data.done_res);
        check_field("status", want.status, out_data.status);
        check_field("read_value", want.read_value, out_data.read_value);
      end
    end
  end

  // Receiver stall pattern, switching mode now and then
  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_mode = stall_mode_e'($urandom_range(0, 3));
      stall_left = $urandom_range(20, 300);
    end else begin
      stall_left--;
    end
    case (stall_mode)
      STALL_NONE:  out_stall <= 1'b0;
      STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
      default:     out_stall <= ((stall_left % 5) < 2);
    endcase
  end

  // Watchdog: too long without any transfer on any channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles == WATCHDOG_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin
    logic [31:0]  phase_limits[PHASES];
    logic [159:0] raw;
    in_item_t     it;
    int unsigned  pick;
    int unsigned  sent;
    int unsigned  burst_left;
    logic [10:0]  id1;
    logic [10:0]  id127;
    logic [63:0]  wr_ok_data;

    phase_limits = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd3, TIMEOUT_RESET, 32'd0, 32'd8, 32'd1};
    phase_limits[6] = $urandom_range(4, 40);
    id1        = 11'(RX_BASE + 1);
    id127      = 11'(RX_BASE + 127);
    wr_ok_data = {32'hFFFF_FFFF, 8'hFF, 16'hFFFF, RSP_WRITE_OK};
    burst_left = 0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed rows, run with the reset timeout
    add_row(ROW_NO_RESULT, ST_OK, bare_item(OP_TICK));
    add_row(ROW_NO_RESULT, ST_OK, bare_item(OP_RX_FRAME));
    add_row(ROW_NO_RESULT, ST_OK, bare_item(OP_RX_FAULT));
    add_row(ROW_NO_RESULT, ST_OK, bare_item(OP_UNUSED));
    add_row(ROW_FINISHED, ST_ERROR, start_item(OP_START_WRITE, 8'd0, '1, '1, '1, 3'd4));
    add_row(ROW_FINISHED, ST_ERROR, start_item(OP_START_READ, 8'd128, '1, '1, '1, 3'd4));
    add_row(ROW_FINISHED, ST_ERROR, start_item(OP_START_WRITE, 8'd1, '0, '0, '0, 3'd0));
    add_row(ROW_FINISHED, ST_ERROR, start_item(OP_START_WRITE, 8'd1, '0, '0, '1, 3'd3));
    add_row(ROW_FINISHED, ST_ERROR, start_item(OP_START_WRITE, 8'd255, '1, '1, '1, 3'd7));
    add_row(ROW_PREDICTED, ST_OK,
            start_item(OP_START_WRITE, 8'd1, 16'hFFFF, 8'hFF, 32'hFFFF_FFFF, 3'd1));
    // start while a transfer is open
    add_row(ROW_FINISHED, ST_ERROR, start_item(OP_START_READ, 8'd127, '0, '0, '0, 3'd0));
    // frames off by one field are dropped
    add_row(ROW_NO_RESULT, ST_OK, frame_item(11'(RX_BASE + 2), FRAME_LENGTH, wr_ok_data));
    add_row(ROW_NO_RESULT, ST_OK, frame_item(id1, 4'd15, wr_ok_data));
    add_row(ROW_NO_RESULT, ST_OK,
            frame_item(id1, FRAME_LENGTH, {32'hFFFF_FFFF, 8'hFF, 16'hFFFE, RSP_WRITE_OK}));
    add_row(ROW_NO_RESULT, ST_OK,
            frame_item(id1, FRAME_LENGTH, {32'hFFFF_FFFF, 8'hFE, 16'hFFFF, RSP_WRITE_OK}));
    add_row(ROW_FINISHED, ST_OK, frame_item(id1, FRAME_LENGTH, wr_ok_data));
    add_row(ROW_PREDICTED, ST_OK, start_item(OP_START_READ, 8'd127, '0, '0, '0, 3'd0));
    add_row(ROW_PREDICTED, ST_OK,
            frame_item(id127, FRAME_LENGTH, {32'h8000_0001, 8'h00, 16'h0000, 8'h5F}));
    add_row(ROW_PREDICTED, ST_OK,
            start_item(OP_START_WRITE, 8'd127, 16'h1234, 8'h56, 32'hA5A5_A5A5, 3'd2));
    add_row(ROW_FINISHED, ST_ABORT,
            frame_item(id127, FRAME_LENGTH, {32'h0, 8'h56, 16'h1234, RSP_ABORT}));
    add_row(ROW_PREDICTED, ST_OK,
            start_item(OP_START_WRITE, 8'd64, 16'h8000, 8'h80, 32'h1234_5678, 3'd4));
    add_row(ROW_FINISHED, ST_ERROR,
            frame_item(11'(RX_BASE + 64), FRAME_LENGTH, {32'h0, 8'h80, 16'h8000, 8'h61}));
    add_row(ROW_PREDICTED, ST_OK, start_item(OP_START_READ, 8'd1, 16'h2000, 8'h01, '0, 3'd0));
    // write acknowledge received for a read
    add_row(ROW_FINISHED, ST_ERROR,
            frame_item(id1, FRAME_LENGTH, {32'hFFFF_FFFF, 8'h01, 16'h2000, RSP_WRITE_OK}));
    add_row(ROW_PREDICTED, ST_OK, start_item(OP_START_READ, 8'd1, 16'h2000, 8'h01, '0, 3'd0));
    add_row(ROW_FINISHED, ST_ERROR, bare_item(OP_RX_FAULT));

    foreach (directed_rows[i])
      send_item(directed_rows[i].item, directed_rows[i].kind, directed_rows[i].st);

    // Random phases, each under its own timeout setting
    for (int p = 0; p < PHASES; p++) begin
      hold_input(1);
      wait_drained();
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_data  <= phase_limits[p];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      wait_limit = phase_limits[p];
      @(negedge clk);
      cfg_valid <= 1'b0;

      sent = 0;
      while (sent < ITEM_TARGET / PHASES) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 40);
          if ($urandom_range(0, 3) != 0) hold_input($urandom_range(1, 6));
        end
        // occasional full drain before going on
        if ($urandom_range(0, 199) == 0) begin
          hold_input(1);
          wait_drained();
        end

        raw  = {$urandom, $urandom, $urandom, $urandom, $urandom};
        it   = raw[$bits(in_item_t)-1:0];
        pick = $urandom_range(0, 99);
        if (xfer_busy) begin
          if (pick < 60) begin
            // response aimed at the open transfer
            it.operation      = OP_RX_FRAME;
            it.rx_id          = 11'(RX_BASE + held_node);
            it.rx_length      = FRAME_LENGTH;
            it.rx_data[23:8]  = held_index;
            it.rx_data[31:24] = held_sub;
            case ($urandom_range(0, 9))
              0, 1, 2, 3: it.rx_data[7:0] = xfer_is_read ?
                                            (RSP_READ_OK | 8'($urandom_range(0, 31))) :
                                            RSP_WRITE_OK;
              4, 5:       it.rx_data[7:0] = RSP_ABORT;
              6, 7:       it.rx_data[7:0] = xfer_is_read ? RSP_WRITE_OK : RSP_READ_OK;
              default:    ;
            endcase
            // near miss: one addressing field broken
            if (pick >= 50) begin
              case ($urandom_range(0, 3))
                0:       it.rx_id = it.rx_id ^ 11'(1 << $urandom_range(0, 10));
                1:       it.rx_length = it.rx_length ^ 4'(1 << $urandom_range(0, 3));
                2:       it.rx_data[23:8] = it.rx_data[23:8] ^ 16'(1 << $urandom_range(0, 15));
                default: it.rx_data[31:24] = it.rx_data[31:24] ^ 8'(1 << $urandom_range(0, 7));
              endcase
            end
          end else if (pick < 80) begin
            it.operation = OP_TICK;
          end else if (pick < 86) begin
            it.operation = OP_RX_FAULT;
          end else if (pick < 92) begin
            it.operation = 3'($urandom_range(0, 1));
          end
        end else if (pick < 70) begin
          // well-formed start
          it.operation = 3'($urandom_range(0, 1));
          it.node_id   = 8'($urandom_range(1, NODE_MAX));
          case ($urandom_range(0, 2))
            0:       it.write_size = 3'd1;
            1:       it.write_size = 3'd2;
            default: it.write_size = 3'd4;
          endcase
        end else if (pick < 85) begin
          // refused start: bad node or bad size
          it.operation = 3'($urandom_range(0, 1));
          if ($urandom_range(0, 1) == 0) begin
            it.node_id = ($urandom_range(0, 1) == 0) ? 8'd0 : {1'b1, it.node_id[6:0]};
          end else begin
            it.operation = OP_START_WRITE;
            it.node_id   = 8'($urandom_range(1, NODE_MAX));
            case ($urandom_range(0, 4))
              0:       it.write_size = 3'd0;
              1:       it.write_size = 3'd3;
              2:       it.write_size = 3'd5;
              3:       it.write_size = 3'd6;
              default: it.write_size = 3'd7;
            endcase
          end
        end

        sent++;
        send_item(it, ROW_PREDICTED, ST_OK);
        burst_left--;
      end
    end

    hold_input(1);
    wait_drained();
    if (mismatch_count == 0 && client_outputs_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
rtl/sdoc_pkg.sv
rtl/sdoc_engine.sv
rtl/sdo_expedited_client.sv
rtl/sdoc_checker.sv
bench/tb.sv
